FILE: src/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon tester package
// Shared payload types, controller state and the command and status bundles.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned PROD_W  = 2 * (COORD_W + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [INDEX_W-1:0]        vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } pip_in_t;

  typedef struct packed {
    logic inside_res;
    logic was_test;
  } pip_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_t;

  typedef struct packed {
    logic load_item;
    logic write_vertex;
    logic issue_prime;
    logic issue_edge;
    logic load_result;
  } pip_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_edge;
    logic pipe_empty;
    logic out_free;
  } pip_sts_t;

endpackage

FILE: src/pip_ctrl.sv
// ----------------------------------------------------------------------------
// Point-in-polygon tester controller
// Sequences vertex writes and the edge walk of a point test.
// ----------------------------------------------------------------------------
module pip_ctrl
  import pip_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  pip_sts_t sts,
  output pip_cmd_t cmd
);

  pip_state_t state_r;
  pip_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (sts.count_zero) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_WRITE: begin
        state_nxt = ST_FINISH;
      end
      ST_PRIME: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.last_edge) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_WRITE: begin
        cmd.write_vertex = 1'b1;
      end
      ST_PRIME: begin
        cmd.issue_prime = 1'b1;
      end
      ST_WALK: begin
        cmd.issue_edge = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_result = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: src/pip_datapath.sv
// ----------------------------------------------------------------------------
// Point-in-polygon tester datapath
// Vertex table, edge pipeline with crossing test, and the result register.
// ----------------------------------------------------------------------------
module pip_datapath
  import pip_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  pip_in_t            in_data,
  input  pip_cmd_t           cmd,
  output pip_sts_t           sts,
  output logic               out_valid,
  input  logic               out_ready,
  output pip_out_t           out_data
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW = COORD_W + 1;

  logic [COUNT_W-1:0]        vcount_r;
  pip_in_t                   item_r;
  logic [COORD_W-1:0]        mem_x [MAX_VERTICES];
  logic [COORD_W-1:0]        mem_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r;
  logic signed [COORD_W-1:0] rd_y_r;
  logic                      rd_vld_r;
  logic                      rd_prime_r;
  logic signed [COORD_W-1:0] pv_x_r;
  logic signed [COORD_W-1:0] pv_y_r;
  logic [AW-1:0]             idx_r;
  logic signed [PROD_W-1:0]  lhs_r;
  logic signed [PROD_W-1:0]  rhs_r;
  logic                      span_r;
  logic                      dypos_r;
  logic                      s2_vld_r;
  logic                      inside_r;
  logic                      out_valid_r;
  pip_out_t                  out_data_r;

  logic [CW-1:0]             n_eff;
  logic [AW-1:0]             last_idx;
  logic [AW-1:0]             rd_addr;
  logic                      rd_en;
  logic                      wr_ok;
  logic [AW-1:0]             wr_addr;
  logic signed [DW-1:0]      d_x;
  logic signed [DW-1:0]      d_dy;
  logic signed [DW-1:0]      d_xe;
  logic signed [DW-1:0]      d_y;
  logic                      up_span;
  logic                      down_span;
  logic                      crossed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vcount_r);
    end
  end

  assign last_idx = AW'(n_eff - CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  assign wr_ok   = 32'(item_r.vertex_index) < 32'(MAX_VERTICES);
  assign wr_addr = AW'(item_r.vertex_index);
  assign rd_en   = cmd.issue_prime | cmd.issue_edge;
  assign rd_addr = cmd.issue_prime ? last_idx : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.write_vertex && wr_ok) begin
      mem_x[wr_addr] <= item_r.coord_x;
      mem_y[wr_addr] <= item_r.coord_y;
    end
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_prime) begin
      idx_r <= '0;
    end else if (cmd.issue_edge) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // The vertex just read is i; the one held from the previous read is j.
  assign d_x  = DW'(item_r.coord_x) - DW'(rd_x_r);
  assign d_dy = DW'(pv_y_r) - DW'(rd_y_r);
  assign d_xe = DW'(pv_x_r) - DW'(rd_x_r);
  assign d_y  = DW'(item_r.coord_y) - DW'(rd_y_r);

  assign up_span   = (rd_y_r <= item_r.coord_y) && (item_r.coord_y < pv_y_r);
  assign down_span = (pv_y_r <= item_r.coord_y) && (item_r.coord_y < rd_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      s2_vld_r <= rd_vld_r && !rd_prime_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prime_r <= cmd.issue_prime;
    end
    if (rd_vld_r) begin
      pv_x_r <= rd_x_r;
      pv_y_r <= rd_y_r;
    end
    if (rd_vld_r && !rd_prime_r) begin
      lhs_r   <= d_x * d_dy;
      rhs_r   <= d_xe * d_y;
      span_r  <= up_span || down_span;
      dypos_r <= up_span;
    end
  end

  assign crossed = span_r && (dypos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      inside_r <= 1'b0;
    end else if (s2_vld_r && crossed) begin
      inside_r <= ~inside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_data_r.was_test   <= item_r.command;
      out_data_r.inside_res <= (item_r.command == CMD_TEST) ? inside_r : 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.count_zero = (n_eff == '0);
  assign sts.last_edge  = (idx_r == last_idx);
  assign sts.pipe_empty = !rd_vld_r && !s2_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

FILE: src/point_in_polygon_tester_unit.sv
// ----------------------------------------------------------------------------
// Point-in-polygon tester
// A vertex write passes through the write state; a test with no vertices in
// use goes straight to finish. A point test reads the last of the n vertices
// in use, then walks one edge per cycle through the single read port of the
// vertex table. One request is worked on at a time; a finished result waits
// in the output register while the next request is taken. Synchronous reset
// clears the vertex count and control state; the vertex table is not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_tester_unit
  import pip_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  pip_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pip_out_t           out_data
);

  pip_cmd_t cmd;
  pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
